// ===== rtl/scfm_pkg.sv =====
// ----------------------------------------------------------------------------
// scfm_pkg
// Item types and codes shared by the second-chance frame manager.
// ----------------------------------------------------------------------------
package scfm_pkg;

   localparam logic [1:0] KIND_REFERENCE = 2'd0;
   localparam logic [1:0] KIND_LOCK      = 2'd1;
   localparam logic [1:0] KIND_UNLOCK    = 2'd2;
   localparam logic [1:0] KIND_RELEASE   = 2'd3;

   localparam logic [1:0] STATUS_OK           = 2'd0;
   localparam logic [1:0] STATUS_ALL_LOCKED   = 2'd1;
   localparam logic [1:0] STATUS_NOT_RESIDENT = 2'd2;
   localparam logic [1:0] STATUS_LOCK_LIMIT   = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] process_id;
      logic [3:0] page_number;
      logic       write_flag;
   } req_type;

   typedef struct packed {
      logic [4:0] frame;
      logic       fault;
      logic       evicted;
      logic [7:0] evicted_process;
      logic [3:0] evicted_page;
      logic       writeback;
      logic [1:0] status;
   } rsp_type;

endpackage

// ===== rtl/second_chance_frame_manager.sv =====
// ----------------------------------------------------------------------------
// second_chance_frame_manager
// Frame table with second-chance replacement over a FIFO of used frames.
// ----------------------------------------------------------------------------
// Items arrive on the req_ channel (valid/stall) and each one gives exactly
// one item on the rsp_ channel. One item is worked on at a time; req_stall is
// low only while the block is idle.
// Every item but a release first sweeps the frame table, one entry per cycle,
// to find the page and the lowest free unlocked frame; that is all a hit, a
// free placement or an unlock needs. A miss with no free frame adds two passes
// over the FIFO (find victim, then rebuild the order into the other bank),
// each step reading a FIFO entry, then its frame entry, then acting on it.
// A release copies the FIFO, dropping the releasing process's frames, then
// sweeps the table. Frame table and FIFO live in single-read-port RAMs.
// After reset the frame table is cleared entry by entry, during which
// req_stall is high. A finished result waits in the output register while
// rsp_stall is high; the next item is taken meanwhile and holds at its end
// until the register frees.
// ----------------------------------------------------------------------------
module second_chance_frame_manager import scfm_pkg::*; #(
   parameter int FRAMES   = 32,
   parameter int LOCK_MAX = 15
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int FW = $clog2(FRAMES);
   localparam int CW = $clog2(FRAMES + 1);
   localparam int LW = $clog2(LOCK_MAX + 1);

   typedef struct packed {
      logic [7:0]    owner;
      logic [3:0]    page;
      logic          used;
      logic          dirty;
      logic [LW-1:0] lock;
      logic          refb;
   } frame_type;

   localparam int EW = $bits(frame_type);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_LOOK, ST_DECIDE,
      ST_A_FQ, ST_A_FR, ST_A_EX,
      ST_B_FQ, ST_B_FR, ST_B_EX, ST_PLACE,
      ST_R_FQ, ST_R_FR, ST_R_EX, ST_R_SWEEP, ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic [CW-1:0] i_ff, i_in, len_ff, len_in, v_ff, v_in, r_ff, r_in;
   logic [CW-1:0] p_ff, p_in, m_ff, m_in, pp_ff, pp_in, mm_ff, mm_in;
   logic          hit_found_ff, hit_found_in, free_found_ff, free_found_in;
   logic          ufound_ff, ufound_in, wrap_ff, wrap_in, bank_ff, bank_in;
   logic [FW-1:0] hit_ff, hit_in, free_ff, free_in, vf_ff, vf_in, fr_ff, fr_in;
   frame_type     hit_e_ff, hit_e_in, e_ff, e_in;
   rsp_type       res_ff, res_in, rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // frame table ram
   logic          fr_we;
   logic [FW-1:0] fr_waddr, fr_raddr;
   frame_type     fr_wdata, fe;
   logic [EW-1:0] fr_rdata;
   // fifo order ram, two banks
   logic          fq_we;
   logic [FW:0]   fq_waddr, fq_raddr;
   logic [FW-1:0] fq_wdata, fq_rdata;

   logic [CW-1:0] im1, len_m1, b_pos;
   frame_type     new_e;

   assign fe = frame_type'(fr_rdata);
   assign im1 = i_ff - CW'(1);
   assign len_m1 = len_ff - CW'(1);

   scfm_ram #(.WIDTH(EW), .DEPTH(FRAMES)) u_frame_ram (
      .clock   (clock),
      .wr_en   (fr_we),
      .wr_addr (fr_waddr),
      .wr_data (fr_wdata),
      .rd_addr (fr_raddr),
      .rd_data (fr_rdata)
   );

   scfm_ram #(.WIDTH(FW), .DEPTH(2 ** (FW + 1))) u_fifo_ram (
      .clock   (clock),
      .wr_en   (fq_we),
      .wr_addr (fq_waddr),
      .wr_data (fq_wdata),
      .rd_addr (fq_raddr),
      .rd_data (fq_rdata)
   );

   // entry for a newly placed page; placed frames start unlocked, or with one lock for a lock item
   always_comb begin
      new_e = '0;
      new_e.owner = req_ff.process_id;
      new_e.page  = req_ff.page_number;
      new_e.used  = 1'b1;
      new_e.dirty = req_ff.write_flag;
      new_e.lock  = (req_ff.kind == KIND_LOCK) ? LW'(1) : '0;
      new_e.refb  = 1'b1;
   end

   // rebuild position: locked prefix, entries after victim, moved ones, victim
   always_comb begin
      if (i_ff == v_ff) begin
         b_pos = len_m1;
      end else if (!wrap_ff && i_ff > v_ff) begin
         b_pos = CW'(p_ff + i_ff - v_ff - CW'(1));
      end else if (fe.lock != '0) begin
         b_pos = pp_ff;
      end else begin
         b_pos = CW'(p_ff + r_ff + mm_ff);
      end
   end

   always_comb begin
      frame_type ent;
      logic      uf;
      ent = '0;
      uf  = ufound_ff;
      state_in = state_ff;
      req_in = req_ff;
      i_in = i_ff; len_in = len_ff; v_in = v_ff; r_in = r_ff;
      p_in = p_ff; m_in = m_ff; pp_in = pp_ff; mm_in = mm_ff;
      hit_found_in = hit_found_ff; free_found_in = free_found_ff;
      ufound_in = ufound_ff; wrap_in = wrap_ff; bank_in = bank_ff;
      hit_in = hit_ff; free_in = free_ff; vf_in = vf_ff; fr_in = fr_ff;
      hit_e_in = hit_e_ff; e_in = e_ff;
      res_in = res_ff; rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      fr_we = 1'b0; fr_waddr = '0; fr_wdata = '0; fr_raddr = i_ff[FW-1:0];
      fq_we = 1'b0; fq_waddr = '0; fq_wdata = '0;
      fq_raddr = {bank_ff, i_ff[FW-1:0]};

      unique case (state_ff)
         ST_CLEAR: begin
            fr_we = 1'b1;
            fr_waddr = i_ff[FW-1:0];
            if (i_ff == CW'(FRAMES - 1)) begin
               i_in = '0;
               state_in = ST_IDLE;
            end else begin
               i_in = i_ff + CW'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               i_in = '0;
               pp_in = '0;
               hit_found_in = 1'b0;
               free_found_in = 1'b0;
               res_in = '0;
               if (req_data.kind != KIND_RELEASE) begin
                  state_in = ST_LOOK;
               end else if (len_ff == '0) begin
                  state_in = ST_R_SWEEP;
               end else begin
                  state_in = ST_R_FQ;
               end
            end
         end
         ST_LOOK: begin
            // read entry i, check entry i-1
            if (i_ff != '0) begin
               if (!hit_found_ff && fe.used && fe.owner == req_ff.process_id &&
                   fe.page == req_ff.page_number) begin
                  hit_found_in = 1'b1;
                  hit_in = im1[FW-1:0];
                  hit_e_in = fe;
               end
               if (!free_found_ff && !fe.used && fe.lock == '0) begin
                  free_found_in = 1'b1;
                  free_in = im1[FW-1:0];
               end
            end
            if (i_ff == CW'(FRAMES)) begin
               state_in = ST_DECIDE;
            end else begin
               i_in = i_ff + CW'(1);
            end
         end
         ST_DECIDE: begin
            state_in = ST_FINISH;
            if (req_ff.kind == KIND_UNLOCK) begin
               if (!hit_found_ff) begin
                  res_in.status = STATUS_NOT_RESIDENT;
               end else begin
                  ent = hit_e_ff;
                  if (ent.lock != '0) begin
                     ent.lock = ent.lock - LW'(1);
                  end
                  fr_we = 1'b1;
                  fr_waddr = hit_ff;
                  fr_wdata = ent;
                  res_in.frame = 5'(hit_ff);
               end
            end else if (hit_found_ff) begin
               ent = hit_e_ff;
               if (req_ff.kind == KIND_REFERENCE) begin
                  ent.refb = 1'b1;
               end
               if (req_ff.write_flag) begin
                  ent.dirty = 1'b1;
               end
               if (req_ff.kind == KIND_LOCK) begin
                  if (ent.lock >= LW'(LOCK_MAX)) begin
                     res_in.status = STATUS_LOCK_LIMIT;
                  end else begin
                     ent.lock = ent.lock + LW'(1);
                  end
               end
               fr_we = 1'b1;
               fr_waddr = hit_ff;
               fr_wdata = ent;
               res_in.frame = 5'(hit_ff);
            end else if (free_found_ff) begin
               fr_we = 1'b1;
               fr_waddr = free_ff;
               fr_wdata = new_e;
               fq_we = 1'b1;
               fq_waddr = {bank_ff, len_ff[FW-1:0]};
               fq_wdata = free_ff;
               len_in = len_ff + CW'(1);
               res_in.frame = 5'(free_ff);
               res_in.fault = 1'b1;
            end else if (len_ff == '0) begin
               res_in.status = STATUS_ALL_LOCKED;
            end else begin
               i_in = '0;
               p_in = '0;
               m_in = '0;
               ufound_in = 1'b0;
               wrap_in = 1'b0;
               state_in = ST_A_FQ;
            end
         end
         ST_A_FQ: begin
            state_in = ST_A_FR;
         end
         ST_A_FR: begin
            fr_raddr = fq_rdata;
            fr_in = fq_rdata;
            state_in = ST_A_EX;
         end
         ST_A_EX: begin
            if (fe.lock != '0) begin
               p_in = p_ff + CW'(1);
            end else if (fe.refb) begin
               // second chance: clear and move behind the others
               ent = fe;
               ent.refb = 1'b0;
               fr_we = 1'b1;
               fr_waddr = fr_ff;
               fr_wdata = ent;
               m_in = m_ff + CW'(1);
               if (!ufound_ff) begin
                  uf = 1'b1;
                  ufound_in = 1'b1;
                  v_in = i_ff;
                  vf_in = fr_ff;
                  e_in = fe;
               end
            end
            if (fe.lock == '0 && !fe.refb) begin
               v_in = i_ff;
               vf_in = fr_ff;
               e_in = fe;
               r_in = CW'(len_m1 - i_ff);
               wrap_in = 1'b0;
               i_in = '0;
               pp_in = '0;
               mm_in = '0;
               state_in = ST_B_FQ;
            end else if (i_ff == len_m1) begin
               if (!uf) begin
                  res_in.status = STATUS_ALL_LOCKED;
                  state_in = ST_FINISH;
               end else begin
                  // every unlocked entry got its chance, first one goes
                  wrap_in = 1'b1;
                  r_in = '0;
                  i_in = '0;
                  pp_in = '0;
                  mm_in = '0;
                  state_in = ST_B_FQ;
               end
            end else begin
               i_in = i_ff + CW'(1);
               state_in = ST_A_FQ;
            end
         end
         ST_B_FQ: begin
            state_in = ST_B_FR;
         end
         ST_B_FR: begin
            fr_raddr = fq_rdata;
            fr_in = fq_rdata;
            state_in = ST_B_EX;
         end
         ST_B_EX: begin
            fq_we = 1'b1;
            fq_waddr = {~bank_ff, b_pos[FW-1:0]};
            fq_wdata = fr_ff;
            if (i_ff != v_ff && (wrap_ff || i_ff < v_ff)) begin
               if (fe.lock != '0) begin
                  pp_in = pp_ff + CW'(1);
               end else begin
                  mm_in = mm_ff + CW'(1);
               end
            end
            if (i_ff == len_m1) begin
               bank_in = ~bank_ff;
               state_in = ST_PLACE;
            end else begin
               i_in = i_ff + CW'(1);
               state_in = ST_B_FQ;
            end
         end
         ST_PLACE: begin
            fr_we = 1'b1;
            fr_waddr = vf_ff;
            fr_wdata = new_e;
            res_in.frame = 5'(vf_ff);
            res_in.fault = 1'b1;
            res_in.evicted = 1'b1;
            res_in.evicted_process = e_ff.owner;
            res_in.evicted_page = e_ff.page;
            res_in.writeback = e_ff.dirty;
            state_in = ST_FINISH;
         end
         ST_R_FQ: begin
            state_in = ST_R_FR;
         end
         ST_R_FR: begin
            fr_raddr = fq_rdata;
            fr_in = fq_rdata;
            state_in = ST_R_EX;
         end
         ST_R_EX: begin
            if (!(fe.used && fe.owner == req_ff.process_id)) begin
               fq_we = 1'b1;
               fq_waddr = {~bank_ff, pp_ff[FW-1:0]};
               fq_wdata = fr_ff;
               pp_in = pp_ff + CW'(1);
            end
            if (i_ff == len_m1) begin
               bank_in = ~bank_ff;
               len_in = pp_in;
               i_in = '0;
               state_in = ST_R_SWEEP;
            end else begin
               i_in = i_ff + CW'(1);
               state_in = ST_R_FQ;
            end
         end
         ST_R_SWEEP: begin
            if (i_ff != '0 && fe.used && fe.owner == req_ff.process_id) begin
               ent = '0;
               ent.lock = fe.lock;
               fr_we = 1'b1;
               fr_waddr = im1[FW-1:0];
               fr_wdata = ent;
            end
            if (i_ff == CW'(FRAMES)) begin
               state_in = ST_FINISH;
            end else begin
               i_in = i_ff + CW'(1);
            end
         end
         ST_FINISH: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_in = res_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         i_ff <= '0;
         len_ff <= '0;
         bank_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff <= i_in;
         len_ff <= len_in;
         bank_ff <= bank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      v_ff <= v_in;
      r_ff <= r_in;
      p_ff <= p_in;
      m_ff <= m_in;
      pp_ff <= pp_in;
      mm_ff <= mm_in;
      hit_found_ff <= hit_found_in;
      free_found_ff <= free_found_in;
      ufound_ff <= ufound_in;
      wrap_ff <= wrap_in;
      hit_ff <= hit_in;
      free_ff <= free_in;
      vf_ff <= vf_in;
      fr_ff <= fr_in;
      hit_e_ff <= hit_e_in;
      e_ff <= e_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= CW'(FRAMES))
      else $error("fifo length beyond frame count");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_FINISH))
      else $error("result shown outside finish step");

   a_rebuild_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_B_EX |-> b_pos < len_ff)
      else $error("rebuilt fifo position out of range");

   a_scan_counts: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_A_EX |-> ({1'b0, p_ff} + {1'b0, m_ff}) < {1'b0, len_ff})
      else $error("scan counts exceed fifo length");

endmodule

// ===== rtl/scfm_ram.sv =====
// ----------------------------------------------------------------------------
// scfm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module scfm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== tb/sv/tb_second_chance_frame_manager.sv =====
// ----------------------------------------------------------------------------
// tb_second_chance_frame_manager
// Drives reference, lock, unlock and release items into the frame manager,
// predicts each response with an independent frame table and second-chance
// FIFO, and compares every response field by field in order.
// ----------------------------------------------------------------------------
module tb_second_chance_frame_manager;
   import scfm_pkg::*;

   localparam int NFRAMES  = 32;
   localparam int NPAGES   = 16;
   localparam int LOCK_TOP = 15;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int error_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int items_sent = 0;
   int responses_seen = 0;
   int scans_seen = 0;

   always #5 clock = ~clock;

   second_chance_frame_manager i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      $display("mismatch %s: got %0d expected %0d", what, got, want);
   endtask

   class frame_scoreboard;
      logic [7:0] owner [NFRAMES];
      logic [3:0] vpage [NFRAMES];
      bit         used [NFRAMES];
      bit         dirty [NFRAMES];
      int         locks [NFRAMES];
      bit         refbit [NFRAMES];
      int         order [$];
      rsp_type    pending [$];

      function void clear();
         for (int i = 0; i < NFRAMES; i++) begin
            owner[i] = '0; vpage[i] = '0; used[i] = 0; dirty[i] = 0;
            locks[i] = 0; refbit[i] = 0;
         end
         order = {};
         pending = {};
      endfunction

      function int lookup(logic [7:0] pid, logic [3:0] pg);
         for (int i = 0; i < NFRAMES; i++)
            if (used[i] && owner[i] == pid && vpage[i] == pg) return i;
         return -1;
      endfunction

      function void load(int f, logic [7:0] pid, logic [3:0] pg);
         owner[f] = pid; vpage[f] = pg; used[f] = 1; dirty[f] = 0; refbit[f] = 1;
      endfunction

      // free unlocked frame first, else second-chance sweep of the fifo
      function int place(logic [7:0] pid, logic [3:0] pg, inout rsp_type r);
         int i;
         int f;
         for (i = 0; i < NFRAMES; i++)
            if (!used[i] && locks[i] == 0) begin
               load(i, pid, pg);
               order.push_back(i);
               return i;
            end
         i = 0;
         while (i < order.size()) begin
            f = order[i];
            if (locks[f] != 0) i++;
            else if (refbit[f]) begin
               refbit[f] = 0;
               order.delete(i);
               order.push_back(f);
            end else begin
               r.evicted = 1'b1;
               r.evicted_process = owner[f];
               r.evicted_page = vpage[f];
               r.writeback = dirty[f];
               order.delete(i);
               order.push_back(f);
               load(f, pid, pg);
               return f;
            end
         end
         return -1;
      endfunction

      function void note_item(req_type q);
         rsp_type r;
         int f;
         logic [3:0] pg;
         r = '0;
         pg = q.page_number % NPAGES;
         if (q.kind == KIND_RELEASE) begin
            for (int i = order.size() - 1; i >= 0; i--)
               if (used[order[i]] && owner[order[i]] == q.process_id) order.delete(i);
            for (int i = 0; i < NFRAMES; i++)
               if (used[i] && owner[i] == q.process_id) begin
                  used[i] = 0; owner[i] = '0; vpage[i] = '0; dirty[i] = 0; refbit[i] = 0;
               end
         end else if (q.kind == KIND_UNLOCK) begin
            f = lookup(q.process_id, pg);
            if (f < 0) r.status = STATUS_NOT_RESIDENT;
            else begin
               if (locks[f] > 0) locks[f]--;
               r.frame = 5'(f);
            end
         end else begin
            f = lookup(q.process_id, pg);
            if (f < 0) begin
               f = place(q.process_id, pg, r);
               if (f < 0) begin
                  r = '0;
                  r.status = STATUS_ALL_LOCKED;
                  pending.push_back(r);
                  return;
               end
               r.fault = 1'b1;
            end else if (q.kind == KIND_REFERENCE) refbit[f] = 1;
            if (q.write_flag) dirty[f] = 1;
            if (q.kind == KIND_LOCK) begin
               if (locks[f] >= LOCK_TOP) r.status = STATUS_LOCK_LIMIT;
               else locks[f]++;
            end
            r.frame = 5'(f);
         end
         pending.push_back(r);
      endfunction

      task check_item(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report_mismatch("unexpected response", 1, 0);
            return;
         end
         want = pending.pop_front();
         if (got.frame != want.frame) report_mismatch("frame", got.frame, want.frame);
         if (got.fault != want.fault) report_mismatch("fault", got.fault, want.fault);
         if (got.evicted != want.evicted)
            report_mismatch("evicted", got.evicted, want.evicted);
         if (got.evicted_process != want.evicted_process)
            report_mismatch("evicted_process", got.evicted_process, want.evicted_process);
         if (got.evicted_page != want.evicted_page)
            report_mismatch("evicted_page", got.evicted_page, want.evicted_page);
         if (got.writeback != want.writeback)
            report_mismatch("writeback", got.writeback, want.writeback);
         if (got.status != want.status) report_mismatch("status", got.status, want.status);
      endtask
   endclass

   frame_scoreboard frames_sb = new();

   // receiver side: sample and stall at each edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         frames_sb.check_item(rsp_data);
         responses_seen++;
         if (rsp_data.evicted) scans_seen++;
      end
      rsp_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
   end

   // valid stays high between back-to-back items and drops only on an idle cycle
   task automatic send_item(input logic [1:0] kind, input logic [7:0] pid,
                            input logic [3:0] pg, input logic wr);
      req_type q;
      q = '{kind: kind, process_id: pid, page_number: pg, write_flag: wr};
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      frames_sb.note_item(q);
      items_sent++;
   endtask

   // mostly a small working set so hits, evictions and locks all occur
   task automatic send_random_item();
      int roll;
      logic [1:0] kind;
      logic [7:0] pid;
      roll = $urandom_range(99);
      if (roll < 60) kind = KIND_REFERENCE;
      else if (roll < 78) kind = KIND_LOCK;
      else if (roll < 95) kind = KIND_UNLOCK;
      else kind = KIND_RELEASE;
      pid = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
      send_item(kind, pid, 4'($urandom), 1'($urandom));
   endtask

   initial begin
      frames_sb.clear();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every kind, special cases
      send_item(KIND_UNLOCK, 8'd0, 4'd0, 1'b0);          // unlock not resident
      send_item(KIND_REFERENCE, 8'hff, 4'hf, 1'b1);
      send_item(KIND_REFERENCE, 8'hff, 4'hf, 1'b0);      // hit
      send_item(KIND_LOCK, 8'h00, 4'h0, 1'b1);           // lock miss
      send_item(KIND_UNLOCK, 8'hff, 4'hf, 1'b0);         // unlock at zero
      for (int i = 0; i < 16; i++)                       // drive lock count past limit
         send_item(KIND_LOCK, 8'hff, 4'hf, i[0]);
      send_item(KIND_UNLOCK, 8'hff, 4'hf, 1'b0);
      send_item(KIND_RELEASE, 8'hff, 4'h0, 1'b0);        // lock count survives release
      send_item(KIND_RELEASE, 8'h55, 4'ha, 1'b1);
      send_item(KIND_RELEASE, 8'h00, 4'h0, 1'b0);

      // fill and lock every frame, then a miss finds all locked
      for (int i = 0; i < NFRAMES; i++) send_item(KIND_LOCK, 8'haa, 4'(i), i[1]);
      for (int i = 0; i < NFRAMES; i++) send_item(KIND_LOCK, 8'hab, 4'(i), 1'b0);
      send_item(KIND_REFERENCE, 8'h12, 4'h3, 1'b1);
      for (int i = 0; i < NFRAMES; i++) send_item(KIND_UNLOCK, 8'haa, 4'(i), 1'b0);
      for (int i = 0; i < NFRAMES; i++) send_item(KIND_UNLOCK, 8'hab, 4'(i), 1'b0);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 65 : 0;
         recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 22 : 0;
         for (int n = 0; n < 420; n++) send_random_item();
      end
      req_valid <= 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;

      while (frames_sb.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("ran %0d items, %0d responses, %0d evictions", items_sent,
               responses_seen, scans_seen);
      if (error_count == 0 && frames_sb.pending.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #100000000;
      $display("timeout");
      $display("DONE: errors detected");
      $finish;
   end

endmodule
